// ----- hdl/assert_macros.svh -----
// assertion macros used by the unquoter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SLU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slu property violated");
`define SLU_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("slu forbidden condition seen");
`else
`define SLU_ASSERT(label, clk, rst_n, prop)
`define SLU_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- hdl/slu_pkg.sv -----
// shared types, constants and helpers of the string literal unquoter
`default_nettype none
package slu_pkg;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [7:0] BYTE_LIMIT = 8'd255;
    localparam logic [7:0] C_DQ   = 8'h22;
    localparam logic [7:0] C_SQ   = 8'h27;
    localparam logic [7:0] C_BQ   = 8'h60;
    localparam logic [7:0] C_BS   = 8'h5C;
    localparam logic [7:0] C_LF   = 8'h0A;
    localparam logic [7:0] C_CR   = 8'h0D;
    localparam logic [7:0] C_LC_A = 8'h61;
    localparam logic [7:0] C_LC_B = 8'h62;
    localparam logic [7:0] C_LC_F = 8'h66;
    localparam logic [7:0] C_LC_N = 8'h6E;
    localparam logic [7:0] C_LC_R = 8'h72;
    localparam logic [7:0] C_LC_T = 8'h74;
    localparam logic [7:0] C_LC_V = 8'h76;
    localparam logic [7:0] C_LC_X = 8'h78;
    localparam logic [7:0] C_LC_U = 8'h75;
    localparam logic [7:0] C_UC_U = 8'h55;
    localparam logic [7:0] C_D0   = 8'h30;
    localparam logic [7:0] C_D7   = 8'h37;
    localparam logic [7:0] C_BEL  = 8'h07;
    localparam logic [7:0] C_BSP  = 8'h08;
    localparam logic [7:0] C_FF   = 8'h0C;
    localparam logic [7:0] C_HT   = 8'h09;
    localparam logic [7:0] C_VT   = 8'h0B;
    // replacement character U+FFFD in utf-8
    localparam logic [7:0] RC_B0  = 8'hEF;
    localparam logic [7:0] RC_B1  = 8'hBF;
    localparam logic [7:0] RC_B2  = 8'hBD;
    localparam logic [20:0] CP_MAX = 21'h10FFFF;
    localparam logic [20:0] SUR_LO = 21'h00D800;
    localparam logic [20:0] SUR_HI = 21'h00DFFF;

    // at most one packet per input byte: replacement runes, then tail bytes, then status
    typedef struct packed {
        logic [2:0]      fffd_cnt;
        logic [2:0]      tail_len;
        logic [3:0][7:0] tail;
        logic            has_status;
        logic            status;
    } t_pkt;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_rune;

    // utf-8 encoding of a code point
    function automatic t_rune utf8_encode(logic [20:0] cp);
        t_rune r;
        r = '0;
        if (cp < 21'h80) begin
            r.b[0] = cp[7:0];
            r.len  = 3'd1;
        end else if (cp < 21'h800) begin
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
            r.len  = 3'd2;
        end else if (cp < 21'h10000) begin
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
            r.len  = 3'd3;
        end else begin
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
            r.len  = 3'd4;
        end
        return r;
    endfunction

    // continuation bytes a lead byte asks for, zero when not a lead
    function automatic logic [1:0] lead_need(logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b >= 8'hC2 && b <= 8'hDF) n = 2'd1;
        else if (b >= 8'hE0 && b <= 8'hEF) n = 2'd2;
        else if (b >= 8'hF0 && b <= 8'hF4) n = 2'd3;
        return n;
    endfunction

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(logic [7:0] b);
        logic [4:0] d;
        d = '0;
        if (b >= 8'h30 && b <= 8'h39) d = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) d = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) d = {1'b1, 4'(b - 8'h37)};
        return d;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/slu_front.sv -----
// front end: parses each input beat into at most one queued packet
`default_nettype none
module slu_front import slu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output t_pkt            o_pkt,
    output logic            o_push
);
    typedef enum logic [1:0] {KIND_NONE, KIND_DOUBLE, KIND_SINGLE, KIND_RAW} t_kind;
    typedef enum logic [2:0] {PH_OPEN, PH_BODY, PH_ESC, PH_HEXB, PH_HEXR, PH_OCT} t_phase;

    t_kind       r_kind, n_kind;
    t_phase      r_phase, n_phase;
    logic [20:0] r_val, n_val;
    logic        r_big, n_big;
    logic [3:0]  r_dig, n_dig;
    logic [7:0]  r_pend [3];
    logic [7:0]  n_pend [3];
    logic [1:0]  r_have, n_have;
    logic [1:0]  r_need, n_need;
    logic        r_chars, n_chars;
    logic        r_err, n_err;
    logic        r_closed, n_closed;

    // parse one byte
    always_comb begin
        logic [7:0]  b;
        logic [7:0]  qb;
        logic        do_body;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [1:0]  nd;
        logic [4:0]  hd;
        logic        ok;
        logic [20:0] v2;
        logic        big2;
        logic [7:0]  ev;
        logic        emit;
        t_rune       ru;
        t_pkt        p;

        b       = i_in_byte;
        qb      = (r_kind == KIND_SINGLE) ? C_SQ : C_DQ;
        do_body = 1'b0;
        lo      = 8'h80;
        hi      = 8'hBF;
        nd      = 2'd0;
        hd      = '0;
        ok      = 1'b0;
        v2      = '0;
        big2    = 1'b0;
        ev      = '0;
        emit    = 1'b0;
        ru      = '0;
        p       = '0;

        n_kind   = r_kind;
        n_phase  = r_phase;
        n_val    = r_val;
        n_big    = r_big;
        n_dig    = r_dig;
        n_pend   = r_pend;
        n_have   = r_have;
        n_need   = r_need;
        n_chars  = r_chars;
        n_err    = r_err;
        n_closed = r_closed;

        if (!r_err) begin
            if (r_closed) begin
                n_err = 1'b1;
            end else if (r_phase == PH_OPEN) begin
                if (b == C_DQ) n_kind = KIND_DOUBLE;
                else if (b == C_SQ) n_kind = KIND_SINGLE;
                else if (b == C_BQ) n_kind = KIND_RAW;
                else n_err = 1'b1;
                n_phase = PH_BODY;
            end else if (r_kind == KIND_RAW) begin
                if (b == C_BQ) begin
                    n_closed = 1'b1;
                end else if (b != C_CR) begin
                    p.tail[0]  = b;
                    p.tail_len = 3'd1;
                end
            end else if (r_phase == PH_BODY) begin
                if (r_have != 2'd0) begin
                    // continuation byte of a pending sequence
                    if (r_have == 2'd1) begin
                        if (r_pend[0] == 8'hE0) lo = 8'hA0;
                        else if (r_pend[0] == 8'hED) hi = 8'h9F;
                        else if (r_pend[0] == 8'hF0) lo = 8'h90;
                        else if (r_pend[0] == 8'hF4) hi = 8'h8F;
                    end
                    if (b >= lo && b <= hi) begin
                        if (r_have >= r_need) begin
                            for (int i = 0; i < 3; i++) begin
                                if (2'(i) < r_have) p.tail[i] = r_pend[i];
                            end
                            p.tail[r_have] = b;
                            p.tail_len     = {1'b0, r_have} + 3'd1;
                            n_have         = 2'd0;
                            n_need         = 2'd0;
                            n_chars        = 1'b1;
                        end else begin
                            n_pend[r_have] = b;
                            n_have         = r_have + 2'd1;
                        end
                    end else begin
                        // broken sequence: one replacement per byte taken
                        p.fffd_cnt = {1'b0, r_have};
                        n_have     = 2'd0;
                        n_need     = 2'd0;
                        n_chars    = 1'b1;
                        if (r_kind == KIND_SINGLE && r_have > 2'd1) n_err = 1'b1;
                        do_body = 1'b1;
                    end
                end else begin
                    do_body = 1'b1;
                end
            end else if (r_phase == PH_ESC) begin
                n_phase = PH_BODY;
                emit    = 1'b1;
                case (b)
                    C_LC_A: ev = C_BEL;
                    C_LC_B: ev = C_BSP;
                    C_LC_F: ev = C_FF;
                    C_LC_N: ev = C_LF;
                    C_LC_R: ev = C_CR;
                    C_LC_T: ev = C_HT;
                    C_LC_V: ev = C_VT;
                    C_BS:   ev = C_BS;
                    C_SQ, C_DQ: begin
                        ev = b;
                        if (b != qb) begin
                            n_err = 1'b1;
                            emit  = 1'b0;
                        end
                    end
                    C_LC_X: begin
                        n_phase = PH_HEXB;
                        n_dig   = 4'd2;
                        n_val   = '0;
                        n_big   = 1'b0;
                        emit    = 1'b0;
                    end
                    C_LC_U: begin
                        n_phase = PH_HEXR;
                        n_dig   = 4'd4;
                        n_val   = '0;
                        n_big   = 1'b0;
                        emit    = 1'b0;
                    end
                    C_UC_U: begin
                        n_phase = PH_HEXR;
                        n_dig   = 4'd8;
                        n_val   = '0;
                        n_big   = 1'b0;
                        emit    = 1'b0;
                    end
                    default: begin
                        emit = 1'b0;
                        if (b >= C_D0 && b <= C_D7) begin
                            n_phase = PH_OCT;
                            n_dig   = 4'd2;
                            n_val   = {18'd0, b[2:0]};
                            n_big   = 1'b0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                endcase
                if (emit) begin
                    p.tail[0]  = ev;
                    p.tail_len = 3'd1;
                    n_chars    = 1'b1;
                end
            end else begin
                // digits of a numeric escape
                if (r_phase == PH_OCT) begin
                    ok   = (b >= C_D0 && b <= C_D7);
                    v2   = {r_val[17:0], b[2:0]};
                    big2 = r_big;
                end else begin
                    hd   = hex_digit(b);
                    ok   = hd[4];
                    v2   = {r_val[16:0], hd[3:0]};
                    big2 = r_big | (r_val[20:17] != 4'd0);
                end
                if (!ok) begin
                    n_err = 1'b1;
                end else begin
                    n_val = v2;
                    n_big = big2;
                    n_dig = r_dig - 4'd1;
                    if (n_dig == 4'd0) begin
                        n_phase = PH_BODY;
                        n_chars = 1'b1;
                        if (r_phase == PH_OCT) begin
                            if (v2 > {13'd0, BYTE_LIMIT}) n_err = 1'b1;
                            p.tail[0]  = v2[7:0];
                            p.tail_len = 3'd1;
                        end else if (r_phase == PH_HEXB) begin
                            p.tail[0]  = v2[7:0];
                            p.tail_len = 3'd1;
                        end else begin
                            if (big2 || v2 > CP_MAX || (v2 >= SUR_LO && v2 <= SUR_HI))
                                n_err = 1'b1;
                            ru         = utf8_encode(v2);
                            p.tail     = ru.b;
                            p.tail_len = ru.len;
                        end
                    end
                end
            end

            // plain body byte of a quoted literal
            if (do_body && !n_err) begin
                if (b == qb) begin
                    if (r_kind == KIND_SINGLE && !n_chars) n_err = 1'b1;
                    else n_closed = 1'b1;
                end else if (b == C_LF) begin
                    n_err = 1'b1;
                end else if (r_kind == KIND_SINGLE && n_chars) begin
                    n_err = 1'b1;
                end else if (b == C_BS) begin
                    n_phase = PH_ESC;
                end else if (b < 8'h80) begin
                    p.tail[0]  = b;
                    p.tail_len = 3'd1;
                    n_chars    = 1'b1;
                end else begin
                    nd = lead_need(b);
                    if (nd == 2'd0) begin
                        p.fffd_cnt = p.fffd_cnt + 3'd1;
                        n_chars    = 1'b1;
                    end else begin
                        n_pend[0] = b;
                        n_have    = 2'd1;
                        n_need    = nd;
                    end
                end
            end
            if (n_err) begin
                p.fffd_cnt = '0;
                p.tail_len = '0;
            end
        end

        // end of literal: status and fresh state
        if (i_in_last) begin
            p.has_status = 1'b1;
            p.status     = n_err | ~n_closed;
            if (p.status) begin
                p.fffd_cnt = '0;
                p.tail_len = '0;
            end
            n_kind   = KIND_NONE;
            n_phase  = PH_OPEN;
            n_val    = '0;
            n_big    = 1'b0;
            n_dig    = '0;
            n_have   = '0;
            n_need   = '0;
            n_chars  = 1'b0;
            n_err    = 1'b0;
            n_closed = 1'b0;
        end

        o_pkt  = p;
        o_push = i_accept && (p.has_status || p.fffd_cnt != 3'd0 || p.tail_len != 3'd0);
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_NONE;
            r_phase  <= PH_OPEN;
            r_val    <= '0;
            r_big    <= 1'b0;
            r_dig    <= '0;
            r_have   <= '0;
            r_need   <= '0;
            r_chars  <= 1'b0;
            r_err    <= 1'b0;
            r_closed <= 1'b0;
        end else if (i_accept) begin
            r_kind   <= n_kind;
            r_phase  <= n_phase;
            r_val    <= n_val;
            r_big    <= n_big;
            r_dig    <= n_dig;
            r_have   <= n_have;
            r_need   <= n_need;
            r_chars  <= n_chars;
            r_err    <= n_err;
            r_closed <= n_closed;
        end
    end

    // pending utf-8 bytes
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/slu_fifo.sv -----
// packet queue between the parser and the serializer
`default_nettype none
module slu_fifo import slu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  t_pkt            i_pkt,
    input  wire logic       i_pop,
    output t_pkt            o_head,
    output logic            o_head_valid,
    output logic            o_full,
    output logic [QAW:0]    o_count
);
    t_pkt           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_head_valid = (r_cnt != '0);
    assign o_full       = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_count      = r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pkt;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/slu_back.sv -----
// back end: walks a packet out one result beat at a time
`default_nettype none
module slu_back import slu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_pkt            i_head,
    input  wire logic       i_head_valid,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_is_status,
    output logic            o_status,
    output logic            o_out_last
);
    logic [2:0] r_fdone, n_fdone;
    logic [1:0] r_sb, n_sb;
    logic [2:0] r_tdone, n_tdone;
    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_is_st, r_st;
    logic       in_f, in_t, is_st, fin, load;

    // pick the next item of the head packet
    always_comb begin
        in_f    = (r_fdone < i_head.fffd_cnt);
        in_t    = !in_f && (r_tdone < i_head.tail_len);
        is_st   = !in_f && !in_t;
        n_fdone = r_fdone;
        n_sb    = r_sb;
        n_tdone = r_tdone;
        n_byte  = '0;
        if (in_f) begin
            case (r_sb)
                2'd0:    n_byte = RC_B0;
                2'd1:    n_byte = RC_B1;
                default: n_byte = RC_B2;
            endcase
            if (r_sb == 2'd2) begin
                n_sb    = 2'd0;
                n_fdone = r_fdone + 3'd1;
            end else begin
                n_sb = r_sb + 2'd1;
            end
        end else if (in_t) begin
            n_byte  = i_head.tail[r_tdone[1:0]];
            n_tdone = r_tdone + 3'd1;
        end
        fin = is_st || (n_fdone == i_head.fffd_cnt && n_tdone == i_head.tail_len
                        && !i_head.has_status);
        load  = i_head_valid && (!r_valid || !i_out_stall);
        o_pop = load && fin;
    end

    // walk counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdone <= '0;
            r_sb    <= '0;
            r_tdone <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_byte  <= n_byte;
            r_is_st <= is_st;
            r_st    <= is_st & i_head.status;
            if (fin) begin
                r_fdone <= '0;
                r_sb    <= '0;
                r_tdone <= '0;
            end else begin
                r_fdone <= n_fdone;
                r_sb    <= n_sb;
                r_tdone <= n_tdone;
            end
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_is_status = r_is_st;
    assign o_status    = r_st;
    assign o_out_last  = r_is_st;
endmodule
`default_nettype wire

// ----- hdl/string_literal_unquoter.sv -----
// top level of the quoted string literal unquoter
//
// Input channel: one beat per byte of a quoted literal (i_in_byte), the
// opening quote first, i_in_last on its final byte. A beat is taken when
// i_in_valid is high and o_in_stall is low.
// Output channel: decoded value bytes, then one status beat (o_is_status,
// o_status 0 ok / 1 syntax error, o_out_last) that ends every literal.
// Taken when o_out_valid is high and i_out_stall is low.
// Throughput: one input byte per cycle while the queue is not full; the parser
// handles every byte combinationally. The output side moves one beat per cycle
// while i_out_stall is low, so a byte that expands to several beats (escapes,
// utf-8 runs, replacements, up to 12) holds the output for all of them while a
// 4-packet queue absorbs input. A byte's packet is written into the queue when
// the byte is taken; its result beats leave through the serializer's output register.
// Reset: synchronous, active low; empties the queue and returns the parser
// to waiting for an opening quote.
// Output stall: the output beat holds; input stalls only when the queue fills.
`default_nettype none
`include "assert_macros.svh"
module string_literal_unquoter import slu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_is_status,
    output logic            o_status,
    output logic            o_out_last
);
    t_pkt         pkt, head;
    logic         push, pop, head_valid, full, accept;
    logic [QAW:0] count;

    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;

    // parser
    slu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_pkt     (pkt),
        .o_push    (push)
    );

    // packet queue
    slu_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pkt        (pkt),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full),
        .o_count      (count)
    );

    // serializer
    slu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_is_status  (o_is_status),
        .o_status     (o_status),
        .o_out_last   (o_out_last)
    );

    // checks
    `SLU_ASSERT(a_count_bound, i_clk, i_rst_n, count <= (QAW+1)'(QDEPTH))
    `SLU_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, push && full)
    `SLU_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, pop && !head_valid)
    `SLU_ASSERT(a_data_clean, i_clk, i_rst_n, (o_out_valid && !o_is_status) |-> (!o_status && !o_out_last))
endmodule
`default_nettype wire

// ----- test/string_literal_unquoter_tb.sv -----
// self-checking testbench for the string literal unquoter: directed and random literals vs. a behavioral decoder
`timescale 1ns / 1ps
`default_nettype none
module string_literal_unquoter_tb import slu_pkg::*;;

    typedef enum logic [1:0] {K_NONE, K_DQ, K_SQ, K_RAW} t_kind;
    typedef enum logic [2:0] {P_OPEN, P_BODY, P_ESC, P_HEXB, P_HEXR, P_OCT} t_phase;

    localparam logic [31:0] CP_FFFD   = 32'hFFFD;
    localparam int          MAX_BEATS = 12;
    localparam int          IDLE_LIMIT = 20000;
    localparam int          RANDOM_BYTES = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       is_status;
        logic       status;
        logic       last;
    } t_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_is_status;
    logic       o_status;
    logic       o_out_last;

    string_literal_unquoter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in_byte(i_in_byte), .i_in_last(i_in_last),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_byte(o_out_byte), .o_is_status(o_is_status),
        .o_status(o_status), .o_out_last(o_out_last)
    );

    // utf-8 encoding of a code point, returns the length
    function automatic int encode_rune(input logic [31:0] cp, output logic [7:0] e [4]);
        if (cp < 32'h80) begin
            e[0] = cp[7:0];
            return 1;
        end else if (cp < 32'h800) begin
            e[0] = {3'b110, cp[10:6]};
            e[1] = {2'b10, cp[5:0]};
            return 2;
        end else if (cp < 32'h10000) begin
            e[0] = {4'b1110, cp[15:12]};
            e[1] = {2'b10, cp[11:6]};
            e[2] = {2'b10, cp[5:0]};
            return 3;
        end
        e[0] = {5'b11110, cp[20:18]};
        e[1] = {2'b10, cp[17:12]};
        e[2] = {2'b10, cp[11:6]};
        e[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    class unquote_scoreboard;
        t_kind       kind;
        t_phase      phase;
        logic [31:0] esc_val;
        int          digits;
        logic [7:0]  pend [3];
        int          have;
        int          need;
        bit          seen;
        bit          err;
        bit          closed;
        t_beat       step_q [$];
        t_beat       expected_q [$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            kind = K_NONE;
            phase = P_OPEN;
            esc_val = '0;
            digits = 0;
            have = 0;
            need = 0;
            seen = 0;
            err = 0;
            closed = 0;
        endfunction

        function void emit(logic [7:0] b);
            if (step_q.size() < MAX_BEATS) step_q.push_back('{b, 1'b0, 1'b0, 1'b0});
        endfunction

        function void emit_rune(logic [31:0] cp);
            logic [7:0] e [4];
            int n;
            n = encode_rune(cp, e);
            for (int i = 0; i < n; i++) emit(e[i]);
        endfunction

        function logic [7:0] quote_ch();
            return (kind == K_SQ) ? C_SQ : C_DQ;
        endfunction

        function bit start_char();
            if (kind == K_SQ && seen) begin
                err = 1;
                return 0;
            end
            return 1;
        endfunction

        function int cont_needed(logic [7:0] b);
            if (b >= 8'hC2 && b <= 8'hDF) return 1;
            if (b >= 8'hE0 && b <= 8'hEF) return 2;
            if (b >= 8'hF0 && b <= 8'hF4) return 3;
            return 0;
        endfunction

        function void body_byte(logic [7:0] b);
            int n;
            if (b == quote_ch()) begin
                if (kind == K_SQ && !seen) err = 1;
                else closed = 1;
                return;
            end
            if (b == C_LF) begin
                err = 1;
                return;
            end
            if (!start_char()) return;
            if (b == C_BS) begin
                phase = P_ESC;
                return;
            end
            if (b < 8'h80) begin
                emit(b);
                seen = 1;
                return;
            end
            n = cont_needed(b);
            if (n == 0) begin
                emit_rune(CP_FFFD);
                seen = 1;
                return;
            end
            pend[0] = b;
            have = 1;
            need = n;
        endfunction

        // broken sequence: one replacement per byte held
        function void flush_pending();
            int h;
            h = have;
            have = 0;
            need = 0;
            emit_rune(CP_FFFD);
            seen = 1;
            for (int i = 1; i < h; i++) begin
                if (!start_char()) return;
                emit_rune(CP_FFFD);
            end
        endfunction

        function void cont_byte(logic [7:0] b);
            logic [7:0] lo, hi;
            lo = 8'h80;
            hi = 8'hBF;
            if (have == 1) begin
                if (pend[0] == 8'hE0) lo = 8'hA0;
                else if (pend[0] == 8'hED) hi = 8'h9F;
                else if (pend[0] == 8'hF0) lo = 8'h90;
                else if (pend[0] == 8'hF4) hi = 8'h8F;
            end
            if (b >= lo && b <= hi) begin
                if (have >= need || have >= 3) begin
                    for (int i = 0; i < have && i < 3; i++) emit(pend[i]);
                    emit(b);
                    have = 0;
                    need = 0;
                    seen = 1;
                end else begin
                    pend[have] = b;
                    have++;
                end
                return;
            end
            flush_pending();
            if (!err) body_byte(b);
        endfunction

        function void escape_byte(logic [7:0] b);
            logic [7:0] v;
            phase = P_BODY;
            case (b)
                C_LC_A: v = C_BEL;
                C_LC_B: v = C_BSP;
                C_LC_F: v = C_FF;
                C_LC_N: v = C_LF;
                C_LC_R: v = C_CR;
                C_LC_T: v = C_HT;
                C_LC_V: v = C_VT;
                C_BS:   v = C_BS;
                C_SQ, C_DQ: begin
                    if (b != quote_ch()) begin
                        err = 1;
                        return;
                    end
                    v = b;
                end
                C_LC_X: begin
                    phase = P_HEXB; digits = 2; esc_val = '0;
                    return;
                end
                C_LC_U: begin
                    phase = P_HEXR; digits = 4; esc_val = '0;
                    return;
                end
                C_UC_U: begin
                    phase = P_HEXR; digits = 8; esc_val = '0;
                    return;
                end
                default: begin
                    if (b >= C_D0 && b <= C_D7) begin
                        phase = P_OCT;
                        digits = 2;
                        esc_val = 32'(b - C_D0);
                        return;
                    end
                    err = 1;
                    return;
                end
            endcase
            emit(v);
            seen = 1;
        endfunction

        function int hex_val(logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
            if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h57);
            if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h37);
            return -1;
        endfunction

        function void digit_byte(logic [7:0] b);
            int x;
            if (phase == P_OCT) begin
                if (b < C_D0 || b > C_D7) begin
                    err = 1;
                    return;
                end
                esc_val = (esc_val << 3) | 32'(b - C_D0);
            end else begin
                x = hex_val(b);
                if (x < 0) begin
                    err = 1;
                    return;
                end
                esc_val = (esc_val << 4) | 32'(x);
            end
            if (digits > 0) digits--;
            if (digits != 0) return;
            if (phase == P_OCT) begin
                if (esc_val > 32'(BYTE_LIMIT)) begin
                    err = 1;
                    return;
                end
                emit(esc_val[7:0]);
            end else if (phase == P_HEXB) begin
                emit(esc_val[7:0]);
            end else begin
                if (esc_val > 32'h10FFFF || (esc_val >= 32'hD800 && esc_val <= 32'hDFFF)) begin
                    err = 1;
                    return;
                end
                emit_rune(esc_val);
            end
            phase = P_BODY;
            seen = 1;
        endfunction

        // one accepted input beat: work out the beats it causes
        function void note_input(logic [7:0] b, logic l);
            bit st;
            step_q.delete();
            if (!err) begin
                if (closed) err = 1;
                else if (phase == P_OPEN) begin
                    if (b == C_DQ) kind = K_DQ;
                    else if (b == C_SQ) kind = K_SQ;
                    else if (b == C_BQ) kind = K_RAW;
                    else err = 1;
                    phase = P_BODY;
                end else if (kind == K_RAW) begin
                    if (b == C_BQ) closed = 1;
                    else if (b != C_CR) emit(b);
                end else if (phase == P_BODY) begin
                    if (have > 0) cont_byte(b);
                    else body_byte(b);
                end else if (phase == P_ESC) escape_byte(b);
                else digit_byte(b);
                if (err) step_q.delete();
            end
            if (l) begin
                st = err || !closed;
                if (st) step_q.delete();
                if (step_q.size() < MAX_BEATS) step_q.push_back('{8'h00, 1'b1, st, 1'b1});
                clear();
            end
            foreach (step_q[i]) expected_q.push_back(step_q[i]);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        // one accepted output beat against the oldest expectation
        function void check_result(t_beat got);
            t_beat want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat data=%h st=%b/%b last=%b",
                                 got.data, got.is_status, got.status, got.last));
                return;
            end
            want = expected_q.pop_front();
            if (got.is_status !== want.is_status || got.status !== want.status ||
                got.last !== want.last || (!want.is_status && got.data !== want.data))
                report($sformatf("exp data=%h st=%b/%b last=%b got data=%h st=%b/%b last=%b",
                                 want.data, want.is_status, want.status, want.last,
                                 got.data, got.is_status, got.status, got.last));
        endfunction
    endclass

    unquote_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int stall_cnt = 0;
    int sent = 0;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver: check accepted beats, stall on a shifting duty pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_out_byte, o_is_status, o_status, o_out_last});
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 48 == 0) stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 80);
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog on cycles where no beat moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // send one input beat, then maybe open a gap
    task automatic send_byte(logic [7:0] b, logic l);
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(b, l);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 1)) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_literal(logic [7:0] q [$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return 8'h30 + n;
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 10);
    endfunction

    function automatic logic [31:0] rand_cp(bit bad_ok);
        logic [31:0] cp;
        case ($urandom_range(0, bad_ok ? 4 : 3))
            0: cp = $urandom_range(0, 32'h7F);
            1: cp = $urandom_range(32'h80, 32'h7FF);
            2: begin
                cp = $urandom_range(32'h800, 32'hFFFF);
                if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = 32'hE000;
            end
            3: cp = $urandom_range(32'h10000, 32'h10FFFF);
            default: cp = $urandom_range(0, 1) ? $urandom_range(32'hD800, 32'hDFFF)
                                                : $urandom_range(32'h110000, 32'hFFFFFFFF);
        endcase
        return cp;
    endfunction

    // one random literal: mostly well formed, some broken
    function automatic void make_literal(ref logic [7:0] q [$]);
        logic [7:0] quote, e [4];
        logic [31:0] cp;
        logic [7:0] simple [10];
        int nchars, n, pick;
        simple = '{C_LC_A, C_LC_B, C_LC_F, C_LC_N, C_LC_R, C_LC_T, C_LC_V, C_BS, C_SQ, C_DQ};
        q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 40) quote = C_DQ;
        else if (pick < 65) quote = C_SQ;
        else if (pick < 85) quote = C_BQ;
        else quote = 8'($urandom_range(0, 255));
        q.push_back(quote);
        if (quote == C_SQ) nchars = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 1;
        else nchars = $urandom_range(0, 4);
        for (int c = 0; c < nchars; c++) begin
            case ($urandom_range(0, 11))
                0, 1, 2: q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                3: begin
                    q.push_back(C_BS);
                    q.push_back(simple[$urandom_range(0, 9)]);
                end
                4: begin
                    q.push_back(C_BS);
                    q.push_back(C_LC_X);
                    q.push_back(hex_char(4'($urandom_range(0, 15))));
                    q.push_back(hex_char(4'($urandom_range(0, 15))));
                end
                5: begin
                    q.push_back(C_BS);
                    q.push_back(C_D0 + 8'($urandom_range(0, 4) == 0 ? $urandom_range(4, 7)
                                                                   : $urandom_range(0, 3)));
                    q.push_back(C_D0 + 8'($urandom_range(0, 7)));
                    q.push_back(C_D0 + 8'($urandom_range(0, 7)));
                end
                6: begin
                    cp = rand_cp(1);
                    q.push_back(C_BS);
                    q.push_back(C_LC_U);
                    for (int k = 3; k >= 0; k--) q.push_back(hex_char(cp[k*4 +: 4]));
                end
                7: begin
                    cp = rand_cp($urandom_range(0, 3) == 0);
                    q.push_back(C_BS);
                    q.push_back(C_UC_U);
                    for (int k = 7; k >= 0; k--) q.push_back(hex_char(cp[k*4 +: 4]));
                end
                8: begin
                    n = encode_rune(rand_cp(0), e);
                    for (int k = 0; k < n; k++) q.push_back(e[k]);
                end
                9: begin
                    q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                    q.push_back(8'($urandom_range(0, 255)));
                end
                10: q.push_back(8'($urandom_range(0, 255)));
                default: begin
                    q.push_back(C_BS);
                    q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) q.push_back(quote);
        else if (pick < 92) begin
            q.push_back(quote);
            q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    initial begin
        logic [7:0] lit [$];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: raw with carriage return, empty and bad single quotes, bad opening,
        // bare newline, hex and octal extremes, missing close, trailing byte
        send_literal('{C_BQ, C_LC_A, C_CR, C_BQ});
        send_literal('{C_SQ, C_SQ});
        send_literal('{8'hFF});
        send_literal('{C_DQ, C_LF, C_DQ});
        send_literal('{C_DQ, C_BS, C_LC_X, 8'h66, 8'h46, C_DQ});
        send_literal('{C_DQ, C_BS, 8'h33, C_D7, C_D7, C_DQ});
        send_literal('{C_DQ, 8'h00});
        send_literal('{C_DQ, C_DQ, 8'h80});
        i_in_valid <= 1'b0;

        // hold off until everything has drained
        while (sb.expected_q.size() != 0) @(posedge i_clk);

        while (sent < RANDOM_BYTES) begin
            make_literal(lit);
            send_literal(lit);
        end
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.expected_q.size() != 0) sb.report("beats left over");
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
